>>> src/ffpa_pkg.sv
`default_nettype none

package ffpa_pkg;

    // Field widths fixed by the request and response formats
    localparam int REQ_W  = 15;
    localparam int ADDR_W = 10;
    localparam int STAT_W = 2;
    // Dividend width: largest byte count plus largest rounding term
    localparam int NUM_W  = 16;
    // Width of a unit count compared against the largest pool
    localparam int UNITS_W = 17;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_DIV,
        OP_FAIL,
        OP_RD_ROVER,
        OP_A_FIRST,
        OP_A_STEP,
        OP_A_EXACT,
        OP_A_SPLIT,
        OP_A_TAIL,
        OP_RD_BP,
        OP_F_EMPTY,
        OP_F_BPSZ,
        OP_F_STEP,
        OP_F_SOLE,
        OP_F_RDNX,
        OP_F_NOUP,
        OP_F_UPNX,
        OP_F_WRBP,
        OP_F_LOWER,
        OP_F_LINK,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [STAT_W-1:0]   status;
    } dp_cmd_t;

    typedef struct packed {
        logic req_zero;
        logic req_big;
        logic free_bad;
        logic empty;
        logic fit;
        logic exact;
        logic p_is_rover;
        logic a_last;
        logic f_hit;
        logic f_found;
        logic f_upper;
        logic f_nx_is_p;
        logic f_last;
        logic f_lower;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/ffpa_if.sv
`default_nettype none

interface ffpa_req_if import ffpa_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [REQ_W-1:0]  req_bytes;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, output cmd, output req_bytes, output free_addr,
                    input ready);
    modport sink   (input valid, input cmd, input req_bytes, input free_addr,
                    output ready);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] alloc_addr;

    modport source (output valid, output status, output alloc_addr, input ready);
    modport sink   (input valid, input status, input alloc_addr, output ready);
endinterface

`default_nettype wire

>>> src/ffpa_datapath.sv
`default_nettype none

module ffpa_datapath import ffpa_pkg::*; #(
    parameter int POOL_UNITS = 1024,
    parameter int UNIT_BYTES = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               st,
    input  wire logic [REQ_W-1:0]  req_bytes,
    input  wire logic [ADDR_W-1:0] free_addr,
    output logic [STAT_W-1:0]      rsp_status,
    output logic [ADDR_W-1:0]      rsp_addr
);

    localparam int AW = $clog2(POOL_UNITS);
    localparam int SW = AW + 1;
    localparam int HW = SW + AW;
    // Reciprocal of the unit size, exact for every dividend below 2**NUM_W
    localparam int RSH = NUM_W + $clog2(UNIT_BYTES);
    localparam int PW  = RSH + NUM_W + 1;
    localparam logic [NUM_W:0]     RECIP     =
        (NUM_W + 1)'(((64'd1 << RSH) + 64'(UNIT_BYTES - 1)) / 64'(UNIT_BYTES));
    localparam logic [NUM_W-1:0]   ROUND_ADD = NUM_W'(UNIT_BYTES - 1);
    localparam logic [SW-1:0]      POOL_SZ   = SW'(POOL_UNITS);
    localparam logic [SW:0]        POOL_SUM  = (SW + 1)'(POOL_UNITS);
    localparam logic [SW-1:0]      LAST_A    = SW'(POOL_UNITS);
    localparam logic [SW-1:0]      LAST_F    = SW'(POOL_UNITS - 1);
    localparam logic [UNITS_W-1:0] POOL_U    = UNITS_W'(POOL_UNITS);

    // Header store: size in the upper bits, next index in the lower bits
    logic [HW-1:0] mem [POOL_UNITS];

    logic [HW-1:0]      rd_q_reg;
    logic [AW-1:0]      rd_addr_reg;
    logic               init_hit_reg;
    logic               init_flag_reg;
    logic [AW-1:0]      rover_reg;
    logic               empty_reg;

    logic [NUM_W-1:0]   num_reg;
    logic               zero_reg;
    logic               fbad_reg;
    logic [AW-1:0]      bp_reg;
    logic [SW-1:0]      bp_size_reg;
    logic [AW-1:0]      prev_reg;
    logic [SW-1:0]      prev_size_reg;
    logic [AW-1:0]      p_reg;
    logic [SW-1:0]      p_size_reg;
    logic [AW-1:0]      nx_reg;
    logic [SW-1:0]      new_size_reg;
    logic [AW-1:0]      new_next_reg;
    logic [SW-1:0]      step_reg;
    logic [STAT_W-1:0]  res_status_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [ADDR_W-1:0]  out_addr_reg;

    logic [SW-1:0]      cur_size;
    logic [AW-1:0]      cur_next;
    logic [UNITS_W-1:0] units_full;
    logic [SW-1:0]      units;
    logic [PW-1:0]      quot_prod;
    logic [NUM_W-1:0]   quot;
    logic [SW-1:0]      rem_size;
    logic [SW:0]        tail_sum;
    logic [SW:0]        tail_wrap;
    logic [AW-1:0]      tail_idx;
    logic [31:0]        bp_calc;
    logic [31:0]        p_inc;
    logic [31:0]        tail_inc;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [HW-1:0]      wr_data;

    // Header as read, with entry zero showing the whole pool until written
    assign cur_size = init_hit_reg ? POOL_SZ : rd_q_reg[HW-1:AW];
    assign cur_next = init_hit_reg ? '0 : rd_q_reg[AW-1:0];

    // Round up to units by reciprocal multiply
    assign quot_prod = PW'(num_reg) * PW'(RECIP);
    assign quot      = quot_prod[RSH +: NUM_W];

    assign units_full = UNITS_W'(num_reg) + UNITS_W'(1);
    assign units      = units_full[SW-1:0];

    // Tail carve position, wrapped into the pool
    assign rem_size  = cur_size - units;
    assign tail_sum  = (SW + 1)'(rd_addr_reg) + (SW + 1)'(rem_size);
    assign tail_wrap = (tail_sum >= POOL_SUM) ? tail_sum - POOL_SUM : tail_sum;
    assign tail_idx  = tail_wrap[AW-1:0];

    assign bp_calc  = 32'(free_addr) - 32'd1;
    assign p_inc    = 32'(rd_addr_reg) + 32'd1;
    assign tail_inc = 32'(nx_reg) + 32'd1;

    // Status toward the controller
    always_comb
    begin
        st.req_zero   = zero_reg;
        st.req_big    = units_full > POOL_U;
        st.free_bad   = fbad_reg;
        st.empty      = empty_reg;
        st.fit        = cur_size >= units;
        st.exact      = cur_size == units;
        st.p_is_rover = rd_addr_reg == rover_reg;
        st.a_last     = step_reg == LAST_A;
        st.f_hit      = (bp_reg == rd_addr_reg) || (bp_reg == cur_next);
        st.f_found    = ((bp_reg > rd_addr_reg) && (bp_reg < cur_next))
                     || ((rd_addr_reg >= cur_next)
                         && ((bp_reg > rd_addr_reg) || (bp_reg < cur_next)));
        st.f_upper    = ((SW + 1)'(bp_reg) + (SW + 1)'(bp_size_reg))
                     == (SW + 1)'(cur_next);
        st.f_nx_is_p  = cur_next == rd_addr_reg;
        st.f_last     = step_reg == LAST_F;
        st.f_lower    = ((SW + 1)'(p_reg) + (SW + 1)'(p_size_reg))
                     == (SW + 1)'(bp_reg);
    end

    // Select header store read and write
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cur_next;
        wr_en   = 1'b0;
        wr_addr = bp_reg;
        wr_data = {cur_size, cur_next};
        case (cmd.op)
            OP_RD_ROVER, OP_F_BPSZ:
            begin
                rd_en   = 1'b1;
                rd_addr = rover_reg;
            end
            OP_A_FIRST, OP_A_STEP, OP_F_STEP, OP_F_RDNX:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_next;
            end
            OP_RD_BP:
            begin
                rd_en   = 1'b1;
                rd_addr = bp_reg;
            end
            OP_A_EXACT:
            begin
                wr_en   = rd_addr_reg != prev_reg;
                wr_addr = prev_reg;
                wr_data = {prev_size_reg, cur_next};
            end
            OP_A_SPLIT:
            begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_reg;
                wr_data = {rem_size, cur_next};
            end
            OP_A_TAIL:
            begin
                wr_en   = 1'b1;
                wr_addr = nx_reg;
                wr_data = {units, AW'(0)};
            end
            OP_F_EMPTY:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg;
                wr_data = {cur_size, bp_reg};
            end
            OP_F_SOLE:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg;
                wr_data = {bp_size_reg + cur_size, bp_reg};
            end
            OP_F_WRBP:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg;
                wr_data = {new_size_reg, new_next_reg};
            end
            OP_F_LOWER:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = {p_size_reg + new_size_reg, new_next_reg};
            end
            OP_F_LINK:
            begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = {p_size_reg, bp_reg};
            end
            default:
            begin
                rd_en = 1'b0;
                wr_en = 1'b0;
            end
        endcase
    end

    // Header store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            rd_addr_reg  <= rd_addr;
            init_hit_reg <= init_flag_reg && (rd_addr == '0);
        end
    end

    // Control state: rover, empty flag, entry zero reset marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rover_reg     <= '0;
            empty_reg     <= 1'b0;
            init_flag_reg <= 1'b1;
        end
        else
        begin
            if (wr_en && (wr_addr == '0))
            begin
                init_flag_reg <= 1'b0;
            end
            case (cmd.op)
                OP_A_EXACT:
                begin
                    rover_reg <= prev_reg;
                    if (rd_addr_reg == prev_reg)
                    begin
                        empty_reg <= 1'b1;
                    end
                end
                OP_A_SPLIT:
                begin
                    rover_reg <= prev_reg;
                end
                OP_F_EMPTY:
                begin
                    rover_reg <= bp_reg;
                    empty_reg <= 1'b0;
                end
                OP_F_SOLE, OP_F_LINK:
                begin
                    rover_reg <= bp_reg;
                end
                OP_F_LOWER:
                begin
                    rover_reg <= p_reg;
                end
                default:
                begin
                    rover_reg <= rover_reg;
                end
            endcase
        end
    end

    // Working registers and result
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                num_reg     <= NUM_W'(req_bytes) + ROUND_ADD;
                zero_reg    <= req_bytes == '0;
                fbad_reg    <= (free_addr == '0) || (32'(free_addr) >= 32'(POOL_UNITS));
                bp_reg      <= bp_calc[AW-1:0];
            end
            OP_DIV:
            begin
                num_reg     <= quot;
            end
            OP_FAIL:
            begin
                res_status_reg <= cmd.status;
                res_addr_reg   <= '0;
            end
            OP_RD_ROVER:
            begin
                step_reg <= '0;
            end
            OP_A_FIRST:
            begin
                prev_reg      <= rd_addr_reg;
                prev_size_reg <= cur_size;
            end
            OP_A_STEP:
            begin
                prev_reg      <= rd_addr_reg;
                prev_size_reg <= cur_size;
                step_reg      <= step_reg + SW'(1);
            end
            OP_A_EXACT:
            begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= p_inc[ADDR_W-1:0];
            end
            OP_A_SPLIT:
            begin
                nx_reg <= tail_idx;
            end
            OP_A_TAIL:
            begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= tail_inc[ADDR_W-1:0];
            end
            OP_F_EMPTY, OP_F_SOLE, OP_F_LOWER, OP_F_LINK:
            begin
                res_status_reg <= ST_OK;
                res_addr_reg   <= '0;
            end
            OP_F_BPSZ:
            begin
                bp_size_reg <= cur_size;
                step_reg    <= '0;
            end
            OP_F_STEP:
            begin
                step_reg <= step_reg + SW'(1);
            end
            OP_F_RDNX:
            begin
                p_reg      <= rd_addr_reg;
                p_size_reg <= cur_size;
            end
            OP_F_NOUP:
            begin
                p_reg        <= rd_addr_reg;
                p_size_reg   <= cur_size;
                new_size_reg <= bp_size_reg;
                new_next_reg <= cur_next;
            end
            OP_F_UPNX:
            begin
                new_size_reg <= bp_size_reg + cur_size;
                new_next_reg <= cur_next;
            end
            OP_LOAD_OUT:
            begin
                out_status_reg <= res_status_reg;
                out_addr_reg   <= res_addr_reg;
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign rsp_status = out_status_reg;
    assign rsp_addr   = out_addr_reg;

endmodule

`default_nettype wire

>>> src/ffpa_ctrl.sv
`default_nettype none

module ffpa_ctrl import ffpa_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire logic     req_cmd,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    input  wire dp_stat_t st,
    output dp_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_DIV,
        S_A_CHK,
        S_A_ROV,
        S_A_WALK,
        S_A_TAIL,
        S_F_CHK,
        S_F_BP,
        S_F_WALK,
        S_F_UPNX,
        S_F_WRBP,
        S_F_FIN,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;

    // Sequence datapath operations
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_START;
                    state_next = (req_cmd == CMD_FREE) ? S_F_CHK : S_A_DIV;
                end
            end
            S_A_DIV:
            begin
                cmd.op     = OP_DIV;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (st.req_zero || st.req_big)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.status = ST_BAD;
                    state_next = S_DONE;
                end
                else if (st.empty)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.status = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_ROVER;
                    state_next = S_A_ROV;
                end
            end
            S_A_ROV:
            begin
                cmd.op     = OP_A_FIRST;
                state_next = S_A_WALK;
            end
            S_A_WALK:
            begin
                if (st.fit)
                begin
                    cmd.op     = st.exact ? OP_A_EXACT : OP_A_SPLIT;
                    state_next = st.exact ? S_DONE : S_A_TAIL;
                end
                else if (st.p_is_rover || st.a_last)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.status = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_A_STEP;
                end
            end
            S_A_TAIL:
            begin
                cmd.op     = OP_A_TAIL;
                state_next = S_DONE;
            end
            S_F_CHK:
            begin
                if (st.free_bad)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.status = ST_BAD;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_RD_BP;
                    state_next = S_F_BP;
                end
            end
            S_F_BP:
            begin
                cmd.op     = st.empty ? OP_F_EMPTY : OP_F_BPSZ;
                state_next = st.empty ? S_DONE : S_F_WALK;
            end
            S_F_WALK:
            begin
                if (st.f_hit)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.status = ST_BAD;
                    state_next = S_DONE;
                end
                else if (st.f_found)
                begin
                    if (st.f_upper && st.f_nx_is_p)
                    begin
                        cmd.op     = OP_F_SOLE;
                        state_next = S_DONE;
                    end
                    else if (st.f_upper)
                    begin
                        cmd.op     = OP_F_RDNX;
                        state_next = S_F_UPNX;
                    end
                    else
                    begin
                        cmd.op     = OP_F_NOUP;
                        state_next = S_F_WRBP;
                    end
                end
                else if (st.f_last)
                begin
                    cmd.op     = OP_FAIL;
                    cmd.status = ST_BAD;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_F_STEP;
                end
            end
            S_F_UPNX:
            begin
                cmd.op     = OP_F_UPNX;
                state_next = S_F_WRBP;
            end
            S_F_WRBP:
            begin
                cmd.op     = OP_F_WRBP;
                state_next = S_F_FIN;
            end
            S_F_FIN:
            begin
                cmd.op     = st.f_lower ? OP_F_LOWER : OP_F_LINK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.op     = OP_LOAD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.op == OP_LOAD_OUT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

>>> src/first_fit_pool_allocator.sv
// First-fit pool allocator over an address-ordered circular free list.
// req channel: cmd selects allocate (req_bytes) or free (free_addr).
// rsp channel: one response per request, status plus alloc_addr.
// Allocate: rounding by reciprocal multiply, then checks and rover read, then
// one free block examined per cycle from the block after the rover, a tail
// carve on a split, and the response load; an exact fit skips the carve.
// Free: checks and header read, then one free block per cycle to the insertion
// point, then the merge reads and writes and the response load. Rejected
// requests go to the response load straight from the check that rejects them.
// Walk length is set by the header store, read once per cycle.
// One request is in work at a time; the input opens again the cycle after the
// response is loaded. A finished response sits in an output register so the
// next request is taken while the receiver stalls; a request that finishes
// meanwhile waits before loading its response.
// Reset: the whole pool is one free block at unit zero, the rover is zero;
// no clearing pass is needed, entry zero is marked until first written.
`default_nettype none

module first_fit_pool_allocator import ffpa_pkg::*; #(
    parameter int POOL_UNITS = 1024,
    parameter int UNIT_BYTES = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    ffpa_req_if.sink   req,
    ffpa_rsp_if.source rsp
);

    dp_cmd_t  cmd;
    dp_stat_t st;

    ffpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_cmd   (req.cmd),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    ffpa_datapath #(
        .POOL_UNITS (POOL_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .req_bytes  (req.req_bytes),
        .free_addr  (req.free_addr),
        .rsp_status (rsp.status),
        .rsp_addr   (rsp.alloc_addr)
    );

    // A response is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD_OUT) |-> (!rsp.valid || rsp.ready))
        else $error("response overwritten while stalled");

    // An accepted request closes the input until its response is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

    // No store or result operation while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> ((cmd.op == OP_NONE) || (cmd.op == OP_START)))
        else $error("datapath operation while idle");

endmodule

`default_nettype wire

>>> bench/first_fit_pool_allocator_checker.sv
`timescale 1ns / 100ps

module first_fit_pool_allocator_checker import ffpa_pkg::*; #(
    parameter int POOL_UNITS = 1024,
    parameter int UNIT_BYTES = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffpa_req_if        req,
    ffpa_rsp_if        rsp,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
    } reply_t;

    int unsigned blk_size [POOL_UNITS];
    int unsigned blk_next [POOL_UNITS];
    int unsigned rover;
    bit          pool_empty;
    reply_t      replies_due [$];

    // Search from the block after the rover for the first block that fits
    function automatic reply_t predict_alloc(int unsigned nbytes);
        reply_t      r;
        int unsigned units;
        int unsigned prev;
        int unsigned p;
        r = '{ST_OK, '0};
        if (nbytes == 0)
        begin
            r.status = ST_BAD;
            return r;
        end
        units = (nbytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        if (units > POOL_UNITS)
        begin
            r.status = ST_BAD;
            return r;
        end
        if (pool_empty)
        begin
            r.status = ST_NOFIT;
            return r;
        end
        prev = rover % POOL_UNITS;
        p = blk_next[prev] % POOL_UNITS;
        for (int s = 0; s <= POOL_UNITS; s++)
        begin
            if (blk_size[p] >= units)
            begin
                if (blk_size[p] == units)
                begin
                    if (p == prev)
                        pool_empty = 1;
                    else
                        blk_next[prev] = blk_next[p];
                end
                else
                begin
                    blk_size[p] -= units;
                    p = (p + blk_size[p]) % POOL_UNITS;
                    blk_size[p] = units;
                end
                rover = prev;
                r.addr = ADDR_W'(p + 1);
                return r;
            end
            if (p == rover % POOL_UNITS)
                break;
            prev = p;
            p = blk_next[p] % POOL_UNITS;
        end
        r.status = ST_NOFIT;
        return r;
    endfunction

    // Insert in address order and merge with free neighbors
    function automatic logic [STAT_W-1:0] pool_free(int unsigned addr);
        int unsigned bp;
        int unsigned p;
        int unsigned nx;
        bit          found;
        found = 0;
        if (addr == 0 || addr >= POOL_UNITS)
            return ST_BAD;
        bp = addr - 1;
        if (pool_empty)
        begin
            blk_next[bp] = bp;
            rover = bp;
            pool_empty = 0;
            return ST_OK;
        end
        p = rover % POOL_UNITS;
        for (int s = 0; s < POOL_UNITS; s++)
        begin
            nx = blk_next[p] % POOL_UNITS;
            if (bp == p || bp == nx)
                return ST_BAD;
            if ((bp > p && bp < nx) || (p >= nx && (bp > p || bp < nx)))
            begin
                found = 1;
                break;
            end
            p = nx;
        end
        if (!found)
            return ST_BAD;
        nx = blk_next[p] % POOL_UNITS;
        if (bp + blk_size[bp] == nx)
        begin
            if (nx == p)
            begin
                blk_size[bp] += blk_size[p];
                blk_next[bp] = bp;
                rover = bp;
                return ST_OK;
            end
            blk_size[bp] += blk_size[nx];
            blk_next[bp] = blk_next[nx] % POOL_UNITS;
        end
        else
            blk_next[bp] = nx;
        if (p + blk_size[p] == bp)
        begin
            blk_size[p] += blk_size[bp];
            blk_next[p] = blk_next[bp];
            rover = p;
        end
        else
        begin
            blk_next[p] = bp;
            rover = bp;
        end
        return ST_OK;
    endfunction

    // Predict on each accepted request, compare each accepted response
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_UNITS; i++)
            begin
                blk_size[i] = 0;
                blk_next[i] = 0;
            end
            blk_size[0] = POOL_UNITS;
            rover = 0;
            pool_empty = 0;
            fail_count = 0;
            replies_due.delete();
            pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected response status %0d addr %0d",
                             $time, rsp.status, rsp.alloc_addr);
                    fail_count++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.alloc_addr !== want.addr)
                    begin
                        $display("%0t: alloc_addr expected %0d actual %0d",
                                 $time, want.addr, rsp.alloc_addr);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.cmd == CMD_ALLOC)
                    want = predict_alloc(req.req_bytes);
                else
                    want = '{pool_free(req.free_addr), '0};
                replies_due.push_back(want);
            end
            pending = replies_due.size();
        end
    end

endmodule

>>> bench/first_fit_pool_allocator_tb.sv
`timescale 1ns / 100ps

module first_fit_pool_allocator_tb import ffpa_pkg::*;;

    localparam int POOL_UNITS = 1024;
    localparam int UNIT_BYTES = 16;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   take_idle;
    int   quiet_cycles;
    int   live_addrs [$];

    ffpa_req_if req ();
    ffpa_rsp_if rsp ();

    first_fit_pool_allocator #(
        .POOL_UNITS(POOL_UNITS),
        .UNIT_BYTES(UNIT_BYTES)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp)
    );

    first_fit_pool_allocator_checker #(
        .POOL_UNITS(POOL_UNITS),
        .UNIT_BYTES(UNIT_BYTES)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Take responses with random stalls
    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(99) >= take_idle);
    end

    // Track live blocks so frees mostly hit real allocations
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.alloc_addr != 0)
            live_addrs.push_back(rsp.alloc_addr);
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Hold one request until accepted, with random idle cycles before it
    task automatic send_request(input logic c, input int nbytes, input int addr);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid     <= 1;
        req.cmd       <= c;
        req.req_bytes <= REQ_W'(nbytes);
        req.free_addr <= ADDR_W'(addr);
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic send_random();
        int pick;
        int idx;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            if ($urandom_range(9) == 0)
                send_request(CMD_ALLOC, $urandom_range(32767), 0);
            else
                send_request(CMD_ALLOC, $urandom_range(1, 400), 0);
        end
        else if (pick < 90 && live_addrs.size() > 0)
        begin
            idx = $urandom_range(live_addrs.size() - 1);
            send_request(CMD_FREE, 0, live_addrs[idx]);
            live_addrs.delete(idx);
        end
        else
            send_request(CMD_FREE, 0, 0);
    endtask

    // Drop the request and wait until every response is back
    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n        = 0;
        send_idle    = 36;
        take_idle    = 52;
        req.valid     = 0;
        req.cmd       = CMD_ALLOC;
        req.req_bytes = '0;
        req.free_addr = '0;
        repeat (12) @(posedge clk);
        rst_n = 1;
        @(posedge clk);

        // Directed: bad sizes, whole pool, empty list, frees of edges
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_ALLOC, 32767, 0);
        send_request(CMD_ALLOC, 16384, 0);
        send_request(CMD_ALLOC, 16369, 0);
        send_request(CMD_ALLOC, 16368, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 0, 0);
        drain();
        send_request(CMD_FREE, 0, 1);
        send_request(CMD_FREE, 0, 1);
        send_request(CMD_ALLOC, 16, 0);
        send_request(CMD_ALLOC, 17, 0);
        send_request(CMD_ALLOC, 100, 0);
        drain();
        while (live_addrs.size() > 0)
            send_request(CMD_FREE, 0, live_addrs.pop_front());
        send_request(CMD_ALLOC, 8000, 0);
        send_request(CMD_ALLOC, 8000, 0);
        send_request(CMD_ALLOC, 8000, 0);
        drain();

        // Random traffic in three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 36 : (ph == 1) ? 52 : 0;
            take_idle = (ph == 0) ? 52 : (ph == 1) ? 36 : 0;
            for (int i = 0; i < 200; i++)
            begin
                send_random();
                if (i % 16 == 15)
                    drain();
            end
            drain();
        end

        req.valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
src/ffpa_pkg.sv
src/ffpa_if.sv
src/ffpa_datapath.sv
src/ffpa_ctrl.sv
src/first_fit_pool_allocator.sv
bench/first_fit_pool_allocator_checker.sv
bench/first_fit_pool_allocator_tb.sv
